FILE: rtl/hdlc_rx_pkg.sv
// Package for the HDLC-like frame receiver: byte codes, FCS-16 constants,
// frame status codes and the unrolled FCS-16 byte update.
// No dependencies.
`default_nettype none

package hdlc_rx_pkg;

    localparam int LINE_BITS = 8;
    localparam int CFG_BITS  = 12;
    localparam int LEN_BITS  = 12;

    localparam logic [7:0]  FLAG_BYTE = 8'h7e;
    localparam logic [7:0]  ESC_BYTE  = 8'h7d;
    localparam logic [7:0]  ESC_XOR   = 8'h20;
    localparam logic [7:0]  ADDR_BYTE = 8'hff;
    localparam logic [7:0]  CTRL_BYTE = 8'h03;
    localparam logic [15:0] FCS_POLY  = 16'h8408;
    localparam logic [15:0] FCS_SEED  = 16'hffff;
    localparam logic [15:0] FCS_GOOD  = 16'hf0b8;
    localparam int          MIN_FRAME = 6;
    localparam logic [CFG_BITS-1:0] MAX_RAW_RESET = 12'd3000;

    typedef enum logic [1:0] {
        ST_GOOD    = 2'd0,
        ST_BAD_FCS = 2'd1,
        ST_SHORT   = 2'd2,
        ST_BAD_HDR = 2'd3
    } frame_status_t;

    // Reflected FCS-16 over one byte, least significant bit first
    function automatic logic [15:0] fcs16_byte(input logic [15:0] fcs_in,
                                               input logic [7:0]  data_in);
        logic [15:0] fcs;
        fcs = fcs_in;
        for (int i = 0; i < 8; i++) begin
            if (fcs[0] ^ data_in[i]) begin
                fcs = (fcs >> 1) ^ FCS_POLY;
            end else begin
                fcs = fcs >> 1;
            end
        end
        return fcs;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/hdlc_frame_receiver.sv
// HDLC-like frame receiver: flag delimiting, octet unstuffing, FCS-16 check,
// two-byte delay that withholds the FCS, end-of-frame status and length.
// Depends on hdlc_rx_pkg.
//
// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid/s_tready    s_tdata: line_byte
// m_        out  m_tvalid/m_tready    m_tdata: data_byte, frame_length;
//                                     m_tuser: data_valid, frame_status;
//                                     m_tlast: frame_end
// cfg_      in   cfg_valid/cfg_ready  cfg_data: max_raw_bytes
//
// One line byte is taken every cycle while s_tready is high; its result, if
// any, sits in the output register from the next cycle on. The frame state
// and the output register are updated in the same cycle as the transfer.
// s_tready drops only while a result waits in the output register and
// m_tready is low. cfg_ready is always high.
// Reset is synchronous on aresetn low; max_raw_bytes returns to 3000.
`default_nettype none

module hdlc_frame_receiver #(
    parameter int COUNT_BITS = 12
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [hdlc_rx_pkg::LINE_BITS-1:0]  s_tdata,   // [7:0] line_byte
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [23:0]                             m_tdata,   // [7:0] data_byte,
                                                               // [19:8] frame_length
    output logic [2:0]                              m_tuser,   // [0] data_valid,
                                                               // [2:1] frame_status
    output logic                                    m_tlast,   // frame_end
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [hdlc_rx_pkg::CFG_BITS-1:0]   cfg_data   // max_raw_bytes
);
    import hdlc_rx_pkg::*;

    localparam int WIDE = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [CFG_BITS-1:0]   limit_reg;
    logic                  esc_reg, esc_next;
    logic [15:0]           fcs_reg, fcs_next;
    logic [COUNT_BITS-1:0] raw_reg, raw_next;
    logic [COUNT_BITS-1:0] unesc_reg, unesc_next;
    logic [7:0]            dly0_reg, dly0_next;
    logic [7:0]            dly1_reg, dly1_next;
    logic                  hdr_bad_reg, hdr_bad_next;

    logic                  m_valid_reg, m_valid_next;
    logic [7:0]            m_byte_reg;
    logic                  m_dvalid_reg;
    logic                  m_end_reg;
    frame_status_t         m_status_reg;
    logic [LEN_BITS-1:0]   m_len_reg;

    logic                  s_xfer;
    logic [7:0]            ub;
    logic                  have;
    logic                  close;
    logic                  res_dvalid;
    logic [7:0]            res_byte;
    frame_status_t         res_status;
    logic [LEN_BITS-1:0]   res_len;
    logic [WIDE-1:0]       limit_w;
    logic [WIDE-1:0]       raw_w;
    logic [WIDE-1:0]       len_w;
    logic [15:0]           fcs_upd;
    logic                  res_valid;

    assign s_tready  = !m_valid_reg || m_tready;
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign fcs_upd = fcs16_byte(fcs_reg, ub);

    always_comb begin
        esc_next     = esc_reg;
        fcs_next     = fcs_reg;
        raw_next     = raw_reg;
        unesc_next   = unesc_reg;
        dly0_next    = dly0_reg;
        dly1_next    = dly1_reg;
        hdr_bad_next = hdr_bad_reg;
        ub           = s_tdata ^ ESC_XOR;
        have         = 1'b0;
        close        = 1'b0;
        res_dvalid   = 1'b0;
        res_byte     = 8'd0;
        res_status   = ST_GOOD;
        res_len      = '0;
        len_w        = '0;

        // Cap the limit at what the counter can hold
        limit_w = WIDE'(limit_reg);
        if (limit_w > WIDE'(COUNT_MAX)) begin
            limit_w = WIDE'(COUNT_MAX);
        end

        if (s_tdata == FLAG_BYTE) begin
            close = (raw_reg != '0);
        end else begin
            if (raw_reg != COUNT_MAX) begin
                raw_next = raw_reg + 1'b1;
            end
            if (esc_reg) begin
                esc_next = 1'b0;
                ub       = s_tdata ^ ESC_XOR;
                have     = 1'b1;
            end else if (s_tdata == ESC_BYTE) begin
                esc_next = 1'b1;
            end else begin
                ub   = s_tdata;
                have = 1'b1;
            end
            if (have) begin
                fcs_next = fcs_upd;
                if (unesc_reg == '0 && ub != ADDR_BYTE) begin
                    hdr_bad_next = 1'b1;
                end
                if (unesc_reg == COUNT_BITS'(1) && ub != CTRL_BYTE) begin
                    hdr_bad_next = 1'b1;
                end
                if (unesc_reg >= COUNT_BITS'(2)) begin
                    res_dvalid = 1'b1;
                    res_byte   = dly1_reg;
                end
                dly1_next = dly0_reg;
                dly0_next = ub;
                if (unesc_reg != COUNT_MAX) begin
                    unesc_next = unesc_reg + 1'b1;
                end
            end
            raw_w = WIDE'(raw_next);
            close = (raw_w >= limit_w);
        end
        raw_w = WIDE'(raw_next);

        if (close) begin
            if (fcs_next != FCS_GOOD) begin
                res_status = ST_BAD_FCS;
            end else if (WIDE'(unesc_next) < WIDE'(MIN_FRAME)) begin
                res_status = ST_SHORT;
            end else if (hdr_bad_next) begin
                res_status = ST_BAD_HDR;
            end else begin
                res_status = ST_GOOD;
                len_w      = WIDE'(unesc_next) - WIDE'(2);
                res_len    = len_w[LEN_BITS-1:0];
            end
            // Return the frame state to idle
            esc_next     = 1'b0;
            fcs_next     = FCS_SEED;
            raw_next     = '0;
            unesc_next   = '0;
            dly0_next    = 8'd0;
            dly1_next    = 8'd0;
            hdr_bad_next = 1'b0;
        end
        res_valid = res_dvalid || close;
    end

    always_comb begin
        if (s_xfer) begin
            m_valid_next = res_valid;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg   <= MAX_RAW_RESET;
            esc_reg     <= 1'b0;
            fcs_reg     <= FCS_SEED;
            raw_reg     <= '0;
            unesc_reg   <= '0;
            dly0_reg    <= 8'd0;
            dly1_reg    <= 8'd0;
            hdr_bad_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                limit_reg <= cfg_data;
            end
            if (s_xfer) begin
                esc_reg     <= esc_next;
                fcs_reg     <= fcs_next;
                raw_reg     <= raw_next;
                unesc_reg   <= unesc_next;
                dly0_reg    <= dly0_next;
                dly1_reg    <= dly1_next;
                hdr_bad_reg <= hdr_bad_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer && res_valid) begin
            m_byte_reg   <= res_byte;
            m_dvalid_reg <= res_dvalid;
            m_end_reg    <= close;
            m_status_reg <= res_status;
            m_len_reg    <= res_len;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_len_reg, m_byte_reg};
    assign m_tuser  = {m_status_reg, m_dvalid_reg};
    assign m_tlast  = m_end_reg;

    // A held result always carries a data byte or an end marker
    a_result_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_dvalid_reg || m_end_reg))
        else $error("empty result in output register");

    // Length is reported only for a good frame end
    a_len_only_good: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (!m_end_reg || m_status_reg != ST_GOOD)) |-> (m_len_reg == '0))
        else $error("frame length without good frame end");

    // Status is meaningful only with the end marker
    a_status_only_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_end_reg) |-> (m_status_reg == ST_GOOD))
        else $error("status without frame end");

    // After a frame end the frame state is back at idle
    a_clear_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && close) |=> (raw_reg == '0 && unesc_reg == '0 && fcs_reg == FCS_SEED
                               && !esc_reg && !hdr_bad_reg))
        else $error("frame state not cleared after frame end");

    // Data bytes appear only after the address and control bytes
    a_data_after_header: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && res_dvalid) |-> (unesc_reg >= COUNT_BITS'(2)))
        else $error("data byte released too early");

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for hdlc_frame_receiver: directed and random line traffic
// against an in-bench deframer/FCS-16 predictor. Depends on hdlc_rx_pkg and the RTL.

module tb_top;

    import hdlc_rx_pkg::*;

    localparam int              CYCLE_LIMIT = 200_000;
    localparam int              HOLD_CYCLES = 300;
    localparam logic [11:0]     COUNT_MAX   = 12'hfff;

    typedef logic [7:0] byte_q_t[$];

    typedef struct packed {
        logic [7:0]    data_byte;
        logic          data_valid;
        logic          frame_end;
        frame_status_t frame_status;
        logic [11:0]   frame_length;
    } rx_result_t;

    typedef struct packed {
        logic        is_cfg;
        logic [11:0] cfg_val;
        logic [7:0]  line;
        logic        typed;
        logic        typed_has;
        rx_result_t  typed_res;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] line_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;     // [7:0] data_byte, [19:8] frame_length
    logic [2:0]  m_tuser;     // [0] data_valid, [2:1] frame_status
    logic        m_tlast;     // frame_end
    logic        cfg_valid;
    logic        cfg_ready;
    logic [11:0] cfg_data;    // max_raw_bytes

    // predictor copy of the frame state
    logic        esc_pend;
    logic [15:0] fcs_acc;
    logic [11:0] raw_cnt;
    logic [11:0] unesc_cnt;
    logic [7:0]  dly [2];
    logic        hdr_bad;
    logic [11:0] limit_reg;

    rx_result_t  expected_q[$];
    stim_row_t   stim_q[$];
    rx_result_t  want;

    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    bit          hold_request = 0;
    int          cycle_cnt = 0;
    int          err_cnt = 0;
    int          lines_sent = 0;
    int          results_seen = 0;
    int          ends_by_status [4] = '{0, 0, 0, 0};

    hdlc_frame_receiver #(.COUNT_BITS(12)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
                 expected_q.size());
        $display("FAIL hdlc_frame_receiver");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [15:0] next_fcs(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] f;
        f = acc ^ {8'h00, d};
        for (int i = 0; i < 8; i++) begin
            f = f[0] ? ((f >> 1) ^ FCS_POLY) : (f >> 1);
        end
        return f;
    endfunction

    function automatic void clear_frame_state();
        esc_pend  = 1'b0;
        fcs_acc   = FCS_SEED;
        raw_cnt   = '0;
        unesc_cnt = '0;
        dly[0]    = '0;
        dly[1]    = '0;
        hdr_bad   = 1'b0;
    endfunction

    // Advance the frame state by one line byte; returns 1 when a result leaves
    function automatic bit deframe_line_byte(input logic [7:0] raw, output rx_result_t res);
        logic [7:0]  b;
        logic [11:0] cap;
        bit          have;
        bit          close;
        res   = '0;
        b     = raw;
        have  = 1'b0;
        close = 1'b0;
        if (raw == FLAG_BYTE) begin
            if (raw_cnt == 0) return 1'b0;
            close = 1'b1;
        end else begin
            if (raw_cnt != COUNT_MAX) raw_cnt++;
            if (esc_pend) begin
                esc_pend = 1'b0;
                b        = raw ^ ESC_XOR;
                have     = 1'b1;
            end else if (raw == ESC_BYTE) begin
                esc_pend = 1'b1;
            end else begin
                have = 1'b1;
            end
            if (have) begin
                fcs_acc = next_fcs(fcs_acc, b);
                if (unesc_cnt == 0 && b != ADDR_BYTE) hdr_bad = 1'b1;
                if (unesc_cnt == 1 && b != CTRL_BYTE) hdr_bad = 1'b1;
                if (unesc_cnt >= 2) begin
                    res.data_byte  = dly[1];
                    res.data_valid = 1'b1;
                end
                dly[1] = dly[0];
                dly[0] = b;
                if (unesc_cnt != COUNT_MAX) unesc_cnt++;
            end
            cap = (limit_reg < COUNT_MAX) ? limit_reg : COUNT_MAX;
            if (raw_cnt >= cap) close = 1'b1;
        end
        if (close) begin
            res.frame_end = 1'b1;
            if (fcs_acc != FCS_GOOD) begin
                res.frame_status = ST_BAD_FCS;
            end else if (unesc_cnt < MIN_FRAME) begin
                res.frame_status = ST_SHORT;
            end else if (hdr_bad) begin
                res.frame_status = ST_BAD_HDR;
            end else begin
                res.frame_status = ST_GOOD;
                res.frame_length = unesc_cnt - 12'd2;
            end
            clear_frame_state();
        end
        return res.data_valid || res.frame_end;
    endfunction

    // ---------------------------------------------------------------- stimulus build

    task automatic push_typed(input logic [7:0] b, input bit has, input rx_result_t res);
        stim_row_t row;
        row           = '0;
        row.line      = b;
        row.typed     = 1'b1;
        row.typed_has = has;
        row.typed_res = res;
        stim_q.push_back(row);
    endtask

    task automatic push_byte(input logic [7:0] b);
        stim_row_t row;
        row      = '0;
        row.line = b;
        stim_q.push_back(row);
    endtask

    task automatic push_cfg(input logic [11:0] v);
        stim_row_t row;
        row         = '0;
        row.is_cfg  = 1'b1;
        row.cfg_val = v;
        stim_q.push_back(row);
    endtask

    // Append FCS (complemented, low byte first), stuff and close with a flag
    task automatic emit_frame(input byte_q_t body, input bit corrupt, input bit extra_esc);
        byte_q_t     full;
        logic [15:0] f;
        int          k;
        f    = FCS_SEED;
        full = body;
        foreach (body[i]) f = next_fcs(f, body[i]);
        f = ~f;
        full.push_back(f[7:0]);
        full.push_back(f[15:8]);
        if (corrupt) begin
            k = $urandom_range(full.size() - 1);
            full[k] = full[k] ^ 8'($urandom_range(1, 255));
        end
        foreach (full[i]) begin
            // an escaped 0x5e would put a flag on the line, so never stuff it
            if (full[i] == FLAG_BYTE || full[i] == ESC_BYTE ||
                (extra_esc && full[i] != (FLAG_BYTE ^ ESC_XOR) && $urandom_range(15) == 0)) begin
                push_byte(ESC_BYTE);
                push_byte(full[i] ^ ESC_XOR);
            end else begin
                push_byte(full[i]);
            end
        end
        push_byte(FLAG_BYTE);
    endtask

    task automatic queue_random_traffic(input int n_rows, input int max_plen);
        int         start;
        int         r;
        int         plen;
        int         k;
        byte_q_t    body;
        logic [7:0] b;
        start = stim_q.size();
        while (stim_q.size() - start < n_rows) begin
            r    = $urandom_range(99);
            plen = ($urandom_range(15) == 0) ? $urandom_range(max_plen) : $urandom_range(12);
            body = {};
            body.push_back(ADDR_BYTE);
            body.push_back(CTRL_BYTE);
            repeat (plen) body.push_back(8'($urandom_range(255)));
            if (r < 55) begin
                emit_frame(body, 1'b0, 1'b1);
            end else if (r < 67) begin
                emit_frame(body, 1'b1, 1'b1);
            end else if (r < 77) begin
                // spoil address or control but keep the FCS right
                k = $urandom_range(1);
                body[k] = body[k] ^ 8'($urandom_range(1, 255));
                emit_frame(body, 1'b0, 1'b1);
            end else if (r < 87) begin
                repeat ($urandom_range(1, 12)) begin
                    case ($urandom_range(7))
                        0:       b = FLAG_BYTE;
                        1:       b = ESC_BYTE;
                        default: b = 8'($urandom_range(255));
                    endcase
                    push_byte(b);
                end
            end else if (r < 94) begin
                // frame cut short by a flag right after an escape
                foreach (body[i]) push_byte(body[i]);
                push_byte(ESC_BYTE);
                push_byte(FLAG_BYTE);
            end else begin
                repeat ($urandom_range(1, 3)) push_byte(FLAG_BYTE);
                emit_frame(body, 1'b0, 1'b0);
            end
        end
    endtask

    task automatic queue_long_traffic();
        byte_q_t    body;
        logic [7:0] b;
        body = {};
        body.push_back(ADDR_BYTE);
        body.push_back(CTRL_BYTE);
        // no stuffing in the payload so the raw count stays below a limit of 130
        repeat (100) begin
            do b = 8'($urandom_range(255)); while (b == FLAG_BYTE || b == ESC_BYTE);
            body.push_back(b);
        end
        emit_frame(body, 1'b0, 1'b0);
        // flag-free run that crosses the raw byte limit
        repeat (140) begin
            do b = 8'($urandom_range(255)); while (b == FLAG_BYTE);
            push_byte(b);
        end
        push_byte(FLAG_BYTE);
    endtask

    // ---------------------------------------------------------------- drivers

    // All driver tasks are entered and left at a falling edge
    task automatic send_line(input stim_row_t row);
        rx_result_t res;
        bit         has;
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row.line;
        do @(posedge aclk); while (!s_tready);
        has = deframe_line_byte(row.line, res);
        if (row.typed) begin
            has = row.typed_has;
            res = row.typed_res;
        end
        if (has) expected_q.push_back(res);
        lines_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_limit(input logic [11:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        limit_reg = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic play_stimulus();
        stim_row_t row;
        while (stim_q.size() != 0) begin
            row = stim_q.pop_front();
            if (row.is_cfg) begin
                s_tvalid <= 1'b0;
                wait_drained();
                write_limit(row.cfg_val);
            end else begin
                send_line(row);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic run_phase(input logic [11:0] limit, input int s_idle, input int r_stall,
                             input bit pressure, input int n_rows);
        push_cfg(limit);
        play_stimulus();
        src_idle_pct  = s_idle;
        snk_stall_pct = r_stall;
        if (pressure) hold_request = 1'b1;
        queue_random_traffic(n_rows, 60);
        play_stimulus();
    endtask

    // ---------------------------------------------------------------- result side

    initial begin : sink_proc
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tlast) ends_by_status[m_tuser[2:1]]++;
            if (expected_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected result: tdata=%06h tuser=%0d tlast=%0b",
                             m_tdata, m_tuser, m_tlast);
            end else begin
                want = expected_q.pop_front();
                if (m_tdata[7:0] !== want.data_byte || m_tuser[0] !== want.data_valid ||
                    m_tlast !== want.frame_end || m_tuser[2:1] !== want.frame_status ||
                    m_tdata[19:8] !== want.frame_length || m_tdata[23:20] !== 4'h0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display({"mismatch: want byte=%02h dv=%0b end=%0b st=%0d len=%0d",
                                  " | got byte=%02h dv=%0b end=%0b st=%0d len=%0d pad=%0h"},
                                 want.data_byte, want.data_valid, want.frame_end,
                                 want.frame_status, want.frame_length,
                                 m_tdata[7:0], m_tuser[0], m_tlast, m_tuser[2:1],
                                 m_tdata[19:8], m_tdata[23:20]);
                end
            end
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        limit_reg = MAX_RAW_RESET;
        clear_frame_state();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: idle flag, escape-only frame, good/bad header/short frames,
        // data and end in one result, limit zero
        push_typed(FLAG_BYTE, 1'b0, '0);
        push_typed(ESC_BYTE, 1'b0, '0);
        push_typed(FLAG_BYTE, 1'b1, '{8'h00, 1'b0, 1'b1, ST_BAD_FCS, 12'd0});
        emit_frame({ADDR_BYTE, CTRL_BYTE, 8'h00, 8'hff, FLAG_BYTE, ESC_BYTE}, 1'b0, 1'b0);
        emit_frame({8'hfe, CTRL_BYTE, 8'h55, 8'haa}, 1'b0, 1'b0);
        emit_frame({ADDR_BYTE, CTRL_BYTE}, 1'b0, 1'b0);
        push_cfg(12'd3);
        push_byte(ADDR_BYTE);
        push_byte(CTRL_BYTE);
        push_byte(8'haa);
        push_cfg(12'd0);
        push_byte(8'h41);
        push_cfg(MAX_RAW_RESET);
        play_stimulus();

        run_phase(MAX_RAW_RESET, 0, 0, 1'b0, 90);
        run_phase(12'd4095, 58, 0, 1'b0, 90);
        run_phase(12'd1, 0, 58, 1'b0, 50);
        run_phase(12'd0, 35, 35, 1'b0, 40);
        run_phase(12'd2000, 0, 0, 1'b1, 120);
        run_phase(12'($urandom_range(6, 60)), 35, 35, 1'b0, 80);

        // one long good frame, then a run that crosses the limit
        push_cfg(12'd130);
        play_stimulus();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        queue_long_traffic();
        push_cfg(MAX_RAW_RESET);
        play_stimulus();

        while (expected_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (expected_q.size() != 0) err_cnt++;

        $display("sent %0d line bytes, checked %0d results, limits 0 to 4095 with stalls",
                 lines_sent, results_seen);
        $display("frame ends good/bad-fcs/short/bad-header: %0d/%0d/%0d/%0d, errors %0d",
                 ends_by_status[ST_GOOD], ends_by_status[ST_BAD_FCS],
                 ends_by_status[ST_SHORT], ends_by_status[ST_BAD_HDR], err_cnt);
        if (err_cnt == 0) begin
            $display("PASS hdlc_frame_receiver");
        end else begin
            $display("FAIL hdlc_frame_receiver");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/hdlc_rx_pkg.sv
rtl/hdlc_frame_receiver.sv
sim/tb_top.sv
